// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the min-square-sum RTL (msq_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define MSQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define MSQ_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/msq_pkg.sv =====
// Package: widths, table request struct and sequencer states for min_square_sum_count.
`default_nettype none
package msq_pkg;

   localparam int MAX_N   = 1023;
   localparam int NUM_W   = 10;
   localparam int CNT_W   = 3;
   localparam int DEPTH   = MAX_N + 1;
   localparam int ADDR_W  = $clog2(DEPTH);
   // running square k*k may step just past MAX_N
   localparam int SQ_W    = ADDR_W + 1;
   // odd increment 2k+1, k up to about sqrt(DEPTH)
   localparam int ODD_W   = ADDR_W / 2 + 2;

   // best count seed: above any candidate (entries are at most 4)
   localparam logic [CNT_W-1:0] BEST_INIT = '1;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CNT_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } tbl_req_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_INIT0 = 6'b000010,
      ST_INIT1 = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_STORE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/msq_if.sv =====
// Valid/ready channel interfaces for the request and response items.
`default_nettype none
interface msq_req_if;
   logic                         valid;
   logic                         ready;
   logic [msq_pkg::NUM_W-1:0]    number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface msq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [msq_pkg::CNT_W-1:0]    min_count;

   modport source (output valid, output min_count, input ready);
   modport sink   (input valid, input min_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/msq_table.sv =====
// Scratch table of best counts: one write port, one registered read port.
`default_nettype none
module msq_table (
   input  wire logic                       clock,
   input  wire msq_pkg::tbl_req_type       tbl_req,
   output logic [msq_pkg::CNT_W-1:0]       rd_data
);
   import msq_pkg::*;

   logic [CNT_W-1:0] mem [0:DEPTH-1];
   logic [CNT_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/msq_ctrl.sv =====
// Sequencer and shared min-compare unit that fill the table bottom-up.
`default_nettype none
`include "assert_macros.svh"
module msq_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   msq_req_if.sink                         req,
   msq_rsp_if.source                       rsp,
   output msq_pkg::tbl_req_type            tbl_req,
   input  wire logic [msq_pkg::CNT_W-1:0]  tbl_rd_data
);
   import msq_pkg::*;

   state_type         state_ff, state_in;
   logic [NUM_W-1:0]  n_ff, n_in;
   logic [ADDR_W-1:0] m_ff, m_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [ODD_W-1:0]  odd_ff, odd_in;
   logic [CNT_W-1:0]  best_ff, best_in;
   logic [CNT_W-1:0]  result_ff, result_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              issue;
   logic [CNT_W-1:0]  cand;

   // a square k*k still fits under m
   assign issue = (state_ff == ST_SCAN) && (sq_ff <= {1'b0, m_ff});
   assign cand  = tbl_rd_data + CNT_W'(1);

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = (state_ff == ST_DONE);
   assign rsp.min_count = result_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      m_in      = m_ff;
      sq_in     = sq_ff;
      odd_in    = odd_ff;
      best_in   = best_ff;
      result_in = result_ff;
      rd_vld_in = 1'b0;
      tbl_req   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               // input is 10 bits, so it never exceeds MAX_N
               n_in = req.number;
               if (req.number <= NUM_W'(1)) begin
                  result_in = CNT_W'(req.number);
                  state_in  = ST_DONE;
               end else begin
                  state_in  = ST_INIT0;
               end
            end
         end
         ST_INIT0: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = ADDR_W'(0);
            tbl_req.wr_data = CNT_W'(0);
            state_in        = ST_INIT1;
         end
         ST_INIT1: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = ADDR_W'(1);
            tbl_req.wr_data = CNT_W'(1);
            m_in            = ADDR_W'(2);
            sq_in           = SQ_W'(1);
            odd_in          = ODD_W'(3);
            best_in         = BEST_INIT;
            state_in        = ST_SCAN;
         end
         ST_SCAN: begin
            // compare the entry read last cycle
            if (rd_vld_ff && (cand < best_ff)) begin
               best_in = cand;
            end
            if (issue) begin
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = m_ff - sq_ff[ADDR_W-1:0];
               sq_in           = sq_ff + SQ_W'(odd_ff);
               odd_in          = odd_ff + ODD_W'(2);
               rd_vld_in       = 1'b1;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = m_ff;
            tbl_req.wr_data = best_ff;
            if (m_ff == ADDR_W'(n_ff)) begin
               result_in = best_ff;
               state_in  = ST_DONE;
            end else begin
               m_in     = m_ff + ADDR_W'(1);
               sq_in    = SQ_W'(1);
               odd_in   = ODD_W'(3);
               best_in  = BEST_INIT;
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      m_ff      <= m_in;
      sq_ff     <= sq_in;
      odd_ff    <= odd_in;
      best_ff   <= best_in;
      result_ff <= result_in;
   end

   // checks
   `MSQ_ASSERT(a_count_range, clock, reset, rsp.valid |-> (result_ff <= CNT_W'(4)), "count above four")
   `MSQ_NEVER(a_read_outside_scan, clock, reset, tbl_req.rd_en && (state_ff != ST_SCAN), "read outside scan")
   `MSQ_ASSERT(a_store_after_scan, clock, reset, (state_ff == ST_STORE) |-> ($past(state_ff) == ST_SCAN), "store not preceded by scan")
   `MSQ_ASSERT(a_store_bounded, clock, reset, (state_ff == ST_STORE) |-> (m_ff <= ADDR_W'(n_ff)), "fill ran past target")

endmodule
`default_nettype wire

// ===== hw/rtl/min_square_sum_count.sv =====
// Top level: fewest perfect squares summing to a number, iterative table fill.
//
// Usage:
//   req channel carries one item, number (10 bits). It is taken when
//   req.valid and req.ready are both high; ready is high only while idle.
//   rsp channel returns one item per request, min_count (3 bits, 0..4).
//   Inputs 0 and 1 answer straight from idle. Other inputs refill a
//   scratch table bottom-up for m = 2..number; entry m is scanned over
//   each square k*k <= m, one table read at a time through the single
//   table read port and the one compare unit, and is then stored.
//   One item is in flight at a time: the next request is taken in the cycle
//   after the result has been handed over.
//   Reset (synchronous, active high) returns the sequencer to idle; the
//   table needs no clearing since each request rewrites what it reads.
//   A stalled receiver holds the result steady on rsp until rsp.ready.
`default_nettype none
module min_square_sum_count (
   input  wire logic  clock,
   input  wire logic  reset,
   msq_req_if.sink    req,
   msq_rsp_if.source  rsp
);
   import msq_pkg::*;

   tbl_req_type      tbl_req;
   logic [CNT_W-1:0] tbl_rd_data;

   msq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .tbl_req     (tbl_req),
      .tbl_rd_data (tbl_rd_data)
   );

   msq_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

endmodule
`default_nettype wire
